// File: sv/drm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_pkg
// Shared constants and types of the range-transition automaton matcher.
// ----------------------------------------------------------------------------
package drm_pkg;

  // default sizes of the automaton
  localparam int NUM_STATES_DEF = 64;
  localparam int MAX_TRANS_DEF  = 8;

  // field widths
  localparam int CMD_W      = 2;
  localparam int STATE_W    = 6;
  localparam int SLOT_W     = 3;
  localparam int CODE_W     = 21;
  localparam int COUNT_W    = 4;
  localparam int BYTE_W     = 8;
  localparam int TAIL_W     = 3;
  localparam int VERDICT_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // range table entry: low, high, target
  localparam int RANGE_W = 2 * CODE_W + STATE_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_TRANS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INFO  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd3;

  // verdict codes
  localparam logic [VERDICT_W-1:0] V_RUNNING  = 2'd0;
  localparam logic [VERDICT_W-1:0] V_ACCEPTED = 2'd1;
  localparam logic [VERDICT_W-1:0] V_REJECTED = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENCODING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 1'd1;

  // decoder result for one byte
  typedef struct packed {
    logic [CODE_W-1:0] code_accum;
    logic [TAIL_W-1:0] tail_left;
    logic              raw_skip;
    logic              ch_valid;
    logic [CODE_W-1:0] ch;
  } dec_t;

endpackage

// File: sv/drm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module drm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/drm_utf8_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_utf8_dec
// Byte decoder: ASCII or UTF-8 gathering, gives the next decode state and
// the character to evaluate, if any.
// ----------------------------------------------------------------------------
module drm_utf8_dec (
  input  logic                         encoding_mode,
  input  logic [drm_pkg::BYTE_W-1:0]   data_byte,
  input  logic [drm_pkg::CODE_W-1:0]   code_accum,
  input  logic [drm_pkg::TAIL_W-1:0]   tail_left,
  input  logic                         raw_skip,
  output drm_pkg::dec_t                dec
);

  logic [3:0]                 lead_len;
  logic [drm_pkg::TAIL_W-1:0] tail_dec;
  logic [drm_pkg::CODE_W-1:0] accum_shift;
  logic [drm_pkg::CODE_W-1:0] byte_ch;

  // count of leading ones of the byte
  always_comb begin
    priority casez (data_byte)
      8'b0???????: lead_len = 4'd0;
      8'b10??????: lead_len = 4'd1;
      8'b110?????: lead_len = 4'd2;
      8'b1110????: lead_len = 4'd3;
      8'b11110???: lead_len = 4'd4;
      8'b111110??: lead_len = 4'd5;
      8'b1111110?: lead_len = 4'd6;
      8'b11111110: lead_len = 4'd7;
      default:     lead_len = 4'd8;
    endcase
  end

  assign tail_dec    = tail_left - drm_pkg::TAIL_W'(1);
  assign accum_shift = {code_accum[drm_pkg::CODE_W-7:0], data_byte[5:0]};
  assign byte_ch     = drm_pkg::CODE_W'(data_byte);

  // next decode state
  always_comb begin
    dec.code_accum = code_accum;
    dec.tail_left  = '0;
    dec.raw_skip   = 1'b0;
    dec.ch_valid   = 1'b0;
    dec.ch         = byte_ch;
    if (!encoding_mode) begin
      dec.ch_valid = 1'b1;
    end else if (tail_left != '0) begin
      // continuation byte, payload bits gathered unless skipping
      dec.tail_left = tail_dec;
      if (!raw_skip) begin
        dec.code_accum = accum_shift;
        dec.ch         = accum_shift;
        dec.ch_valid   = (tail_dec == '0);
      end
      dec.raw_skip = (tail_dec == '0) ? 1'b0 : raw_skip;
    end else begin
      // lead byte
      unique case (lead_len)
        4'd0, 4'd1: begin
          dec.ch_valid = 1'b1;
        end
        4'd2: begin
          dec.code_accum = drm_pkg::CODE_W'(data_byte[4:0]);
          dec.tail_left  = drm_pkg::TAIL_W'(1);
        end
        4'd3: begin
          dec.code_accum = drm_pkg::CODE_W'(data_byte[3:0]);
          dec.tail_left  = drm_pkg::TAIL_W'(2);
        end
        4'd4: begin
          dec.code_accum = drm_pkg::CODE_W'(data_byte[2:0]);
          dec.tail_left  = drm_pkg::TAIL_W'(3);
        end
        default: begin
          // raw lead, evaluated at once, its tail skipped
          dec.ch_valid  = 1'b1;
          dec.raw_skip  = 1'b1;
          dec.tail_left = drm_pkg::TAIL_W'(lead_len - 4'd1);
        end
      endcase
    end
  end

endmodule

// File: sv/dfa_range_matcher_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfa_range_matcher_utf8
// Matches byte strings against a loaded automaton whose transitions are
// code point ranges, decoding bytes as ASCII or UTF-8.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   command, state_index, slot,
//                                             range_low, range_high,
//                                             target_state, accept_flag,
//                                             transition_count, data_byte
//   out      output     out_valid / out_ready matched, cut_sequence
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Load words are written straight into the tables. A data byte reads its
// state info in S_INFO and goes back to idle if it completes no character,
// meets a decided verdict or an empty state; one that is evaluated scans
// its ordered slots in S_SCAN, one slot a cycle through the range table's
// single read port; a hit reads the target's accept flag in S_TACC.
// An end word waits in S_END until the output register is free.
// Reset clears control state and the state-info valid bits; the range
// table is not cleared. Items are taken one at a time; a waiting result
// does not stall load or data words.
// ----------------------------------------------------------------------------
module dfa_range_matcher_utf8 #(
  parameter int NUM_STATES      = drm_pkg::NUM_STATES_DEF,
  parameter int MAX_TRANSITIONS = drm_pkg::MAX_TRANS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // item channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [drm_pkg::CMD_W-1:0]        command,
  input  logic [drm_pkg::STATE_W-1:0]      state_index,
  input  logic [drm_pkg::SLOT_W-1:0]       slot,
  input  logic [drm_pkg::CODE_W-1:0]       range_low,
  input  logic [drm_pkg::CODE_W-1:0]       range_high,
  input  logic [drm_pkg::STATE_W-1:0]      target_state,
  input  logic                             accept_flag,
  input  logic [drm_pkg::COUNT_W-1:0]      transition_count,
  input  logic [drm_pkg::BYTE_W-1:0]       data_byte,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             matched,
  output logic                             cut_sequence,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [drm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SW = $clog2(NUM_STATES);
  localparam int CW = $clog2(MAX_TRANSITIONS + 1);
  localparam int IW = CW + 1;
  localparam int AW = $clog2(NUM_STATES * MAX_TRANSITIONS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INFO = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TACC = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  logic [2:0]                        st;
  logic                              encoding_mode;
  logic [drm_pkg::STATE_W-1:0]       start_state;
  logic [drm_pkg::STATE_W-1:0]       current_state;
  logic                              at_start;
  logic [drm_pkg::VERDICT_W-1:0]     verdict;
  logic [drm_pkg::CODE_W-1:0]        code_accum;
  logic [drm_pkg::TAIL_W-1:0]        tail_left;
  logic                              raw_skip;
  logic [drm_pkg::CODE_W-1:0]        ch_q;
  logic                              ch_pend;
  logic                              begin_q;
  logic                              info_ok;
  logic [CW-1:0]                     cnt_q;
  logic [CW-1:0]                     scan_k;
  logic [AW-1:0]                     rng_addr;
  logic [NUM_STATES-1:0]             info_valid;

  logic                              in_fire;
  logic [drm_pkg::STATE_W-1:0]       cs_eff;
  drm_pkg::dec_t                     dec;

  // memory ports
  logic                              rng_wr_en;
  logic [AW-1:0]                     rng_wr_addr;
  logic [drm_pkg::RANGE_W-1:0]       rng_wr_data;
  logic                              rng_rd_en;
  logic [AW-1:0]                     rng_rd_addr;
  logic [drm_pkg::RANGE_W-1:0]       rng_rd_data;
  logic                              info_wr_en;
  logic [SW-1:0]                     info_wr_addr;
  logic [IW-1:0]                     info_wr_data;
  logic                              info_rd_en;
  logic [drm_pkg::STATE_W-1:0]       info_sel;
  logic                              info_rd_ok;
  logic [IW-1:0]                     info_rd_data;

  logic                              info_acc;
  logic [CW-1:0]                     info_cnt;
  logic [drm_pkg::VERDICT_W-1:0]     v_eff;
  logic [drm_pkg::CODE_W-1:0]        ent_low;
  logic [drm_pkg::CODE_W-1:0]        ent_high;
  logic [drm_pkg::STATE_W-1:0]       ent_target;
  logic                              hit;
  logic                              last_slot;
  logic                              out_free;

  assign in_ready  = (st == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cs_eff    = at_start ? start_state : current_state;
  assign out_free  = !out_valid || out_ready;

  // byte decoder
  drm_utf8_dec u_dec (
    .encoding_mode (encoding_mode),
    .data_byte     (data_byte),
    .code_accum    (code_accum),
    .tail_left     (tail_left),
    .raw_skip      (raw_skip),
    .dec           (dec)
  );

  // load writes
  assign rng_wr_en    = in_fire && (command == drm_pkg::CMD_TRANS)
                        && (int'(state_index) < NUM_STATES)
                        && (int'(slot) < MAX_TRANSITIONS);
  assign rng_wr_addr  = AW'(int'(state_index) * MAX_TRANSITIONS + int'(slot));
  assign rng_wr_data  = {target_state, range_high, range_low};
  assign info_wr_en   = in_fire && (command == drm_pkg::CMD_INFO)
                        && (int'(state_index) < NUM_STATES);
  assign info_wr_addr = SW'(state_index);
  assign info_wr_data = {accept_flag,
                         (int'(transition_count) > MAX_TRANSITIONS) ?
                           CW'(MAX_TRANSITIONS) : CW'(transition_count)};

  // range entry fields and compare
  assign ent_low    = rng_rd_data[drm_pkg::CODE_W-1:0];
  assign ent_high   = rng_rd_data[2*drm_pkg::CODE_W-1:drm_pkg::CODE_W];
  assign ent_target = rng_rd_data[drm_pkg::RANGE_W-1:2*drm_pkg::CODE_W];
  assign hit        = (ch_q >= ent_low) && (ch_q <= ent_high);
  assign last_slot  = ((scan_k + CW'(1)) == cnt_q);

  // state info as read, unwritten or bad states read as zero
  assign info_acc = info_ok && info_rd_data[IW-1];
  assign info_cnt = info_ok ? info_rd_data[CW-1:0] : '0;
  assign v_eff    = (begin_q && info_acc) ? drm_pkg::V_ACCEPTED : verdict;

  // state info read select
  always_comb begin
    info_rd_en = 1'b0;
    info_sel   = cs_eff;
    if (in_fire && ((command == drm_pkg::CMD_DATA) || (command == drm_pkg::CMD_END))) begin
      info_rd_en = 1'b1;
    end else if ((st == S_SCAN) && hit) begin
      info_rd_en = 1'b1;
      info_sel   = ent_target;
    end
  end

  assign info_rd_ok = (int'(info_sel) < NUM_STATES) && info_valid[SW'(info_sel)];

  // range table read select
  always_comb begin
    rng_rd_en   = 1'b0;
    rng_rd_addr = rng_addr + AW'(1);
    if ((st == S_INFO) && ch_pend && (v_eff == drm_pkg::V_RUNNING) && (info_cnt != '0)) begin
      rng_rd_en   = 1'b1;
      rng_rd_addr = AW'(int'(current_state) * MAX_TRANSITIONS);
    end else if ((st == S_SCAN) && !hit && !last_slot) begin
      rng_rd_en = 1'b1;
    end
  end

  drm_ram #(
    .WIDTH (drm_pkg::RANGE_W),
    .DEPTH (NUM_STATES * MAX_TRANSITIONS)
  ) u_range_ram (
    .clk     (clk),
    .wr_en   (rng_wr_en),
    .wr_addr (rng_wr_addr),
    .wr_data (rng_wr_data),
    .rd_en   (rng_rd_en),
    .rd_addr (rng_rd_addr),
    .rd_data (rng_rd_data)
  );

  drm_ram #(
    .WIDTH (IW),
    .DEPTH (NUM_STATES)
  ) u_info_ram (
    .clk     (clk),
    .wr_en   (info_wr_en),
    .wr_addr (info_wr_addr),
    .wr_data (info_wr_data),
    .rd_en   (info_rd_en),
    .rd_addr (SW'(info_sel)),
    .rd_data (info_rd_data)
  );

  // payload and lookup registers
  always_ff @(posedge clk) begin
    if (info_rd_en) begin
      info_ok <= info_rd_ok;
    end
    if (rng_rd_en) begin
      rng_addr <= rng_rd_addr;
    end
    if (in_fire) begin
      begin_q <= at_start;
      ch_q    <= dec.ch;
    end
    if (st == S_INFO) begin
      cnt_q  <= info_cnt;
      scan_k <= '0;
    end else if (st == S_SCAN) begin
      scan_k <= scan_k + CW'(1);
    end
    if ((st == S_END) && out_free) begin
      matched      <= (verdict == drm_pkg::V_ACCEPTED) || (begin_q && info_acc);
      cut_sequence <= (tail_left != '0);
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      encoding_mode <= 1'b0;
      start_state   <= '0;
      current_state <= '0;
      at_start      <= 1'b1;
      verdict       <= drm_pkg::V_RUNNING;
      code_accum    <= '0;
      tail_left     <= '0;
      raw_skip      <= 1'b0;
      ch_pend       <= 1'b0;
      out_valid     <= 1'b0;
      info_valid    <= '0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          drm_pkg::CFG_ENCODING: encoding_mode <= cfg_data[0];
          drm_pkg::CFG_START:    start_state   <= cfg_data;
          default:               ;
        endcase
      end

      // result word raised by an end word, dropped once taken
      if ((st == S_END) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (info_wr_en) begin
        info_valid[info_wr_addr] <= 1'b1;
      end

      unique case (st)
        S_IDLE: begin
          if (in_fire) begin
            unique case (command)
              drm_pkg::CMD_DATA: begin
                at_start      <= 1'b0;
                current_state <= cs_eff;
                code_accum    <= dec.code_accum;
                tail_left     <= dec.tail_left;
                raw_skip      <= dec.raw_skip;
                ch_pend       <= dec.ch_valid;
                st            <= S_INFO;
              end
              drm_pkg::CMD_END: begin
                current_state <= cs_eff;
                st            <= S_END;
              end
              default: ;
            endcase
          end
        end
        // start-state accept check, empty-state reject, else first slot fetch
        S_INFO: begin
          if (ch_pend && (v_eff == drm_pkg::V_RUNNING) && (info_cnt == '0)) begin
            verdict <= drm_pkg::V_REJECTED;
          end else begin
            verdict <= v_eff;
          end
          if (ch_pend && (v_eff == drm_pkg::V_RUNNING) && (info_cnt != '0)) begin
            st <= S_SCAN;
          end else begin
            st <= S_IDLE;
          end
        end
        // one ordered slot a cycle, first hit wins
        S_SCAN: begin
          if (hit) begin
            current_state <= ent_target;
            st            <= S_TACC;
          end else if (last_slot) begin
            verdict <= drm_pkg::V_REJECTED;
            st      <= S_IDLE;
          end
        end
        S_TACC: begin
          if (info_acc) begin
            verdict <= drm_pkg::V_ACCEPTED;
          end
          st <= S_IDLE;
        end
        // verdict out and restart
        S_END: begin
          if (out_free) begin
            at_start   <= 1'b1;
            verdict    <= drm_pkg::V_RUNNING;
            code_accum <= '0;
            tail_left  <= '0;
            raw_skip   <= 1'b0;
            st         <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // checks
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (st == S_SCAN) |-> (scan_k < cnt_q))
    else $error("slot scan ran past the state's transition count");

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    ((st == S_END) && out_free) |=> (out_valid && at_start && (st == S_IDLE)))
    else $error("end word did not yield a result and a restart");

  a_raw_tail: assert property (@(posedge clk) disable iff (rst)
    raw_skip |-> (tail_left != '0))
    else $error("raw skip set with no tail pending");

  a_rng_read: assert property (@(posedge clk) disable iff (rst)
    rng_rd_en |-> ((verdict == drm_pkg::V_RUNNING) && ch_pend))
    else $error("range table read with no character to evaluate");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the range-transition automaton matcher. A queue of
// load, data and end words feeds a valid/ready driver; a word-level model of
// the matcher predicts the verdict of every end word, and a monitor checks
// each result word against the oldest prediction. Phases switch encoding,
// start state and the amount of idling on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int  NUM_ST       = drm_pkg::NUM_STATES_DEF;
  localparam int  MAX_TR       = drm_pkg::MAX_TRANS_DEF;
  localparam int  SETTLE       = 24;
  localparam int  TIMEOUT_NS   = 2_000_000;
  localparam int  HOLD_OFF     = 300;
  localparam bit  ENC_BYTES    = 1'b0;
  localparam bit  ENC_UTF8     = 1'b1;
  localparam logic [drm_pkg::CODE_W-1:0] CODE_MAX = '1;

  // one input word
  typedef struct packed {
    logic [drm_pkg::CMD_W-1:0]   cmd;
    logic [drm_pkg::STATE_W-1:0] st;
    logic [drm_pkg::SLOT_W-1:0]  slot;
    logic [drm_pkg::CODE_W-1:0]  lo;
    logic [drm_pkg::CODE_W-1:0]  hi;
    logic [drm_pkg::STATE_W-1:0] tgt;
    logic                        acc;
    logic [drm_pkg::COUNT_W-1:0] cnt;
    logic [drm_pkg::BYTE_W-1:0]  data;
  } word_t;

  // one verdict
  typedef struct packed {
    logic matched;
    logic cut;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic matched;
  logic cut_sequence;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [drm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [drm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  word_t cur_word = '0;

  // bench bookkeeping
  word_t    word_q[$];
  verdict_t verdict_q[$];
  word_t    next_word;
  verdict_t want_v;
  int       words_sent = 0;
  int       words_taken = 0;
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       hold_reqs = 0;
  int       hold_seen = 0;
  int       hold_off_left = 0;
  bit       in_taken = 1'b0;
  bit       slot_set[NUM_ST][MAX_TR];
  logic [drm_pkg::STATE_W-1:0] active_st[8];

  // matcher model state
  bit                            enc_mode = ENC_BYTES;
  bit [drm_pkg::STATE_W-1:0]     start_st = '0;
  bit [drm_pkg::CODE_W-1:0]      tr_lo[NUM_ST*MAX_TR];
  bit [drm_pkg::CODE_W-1:0]      tr_hi[NUM_ST*MAX_TR];
  bit [drm_pkg::STATE_W-1:0]     tr_tg[NUM_ST*MAX_TR];
  bit                            st_acc[NUM_ST];
  bit [drm_pkg::COUNT_W-1:0]     st_cnt[NUM_ST];
  bit [drm_pkg::STATE_W-1:0]     cur_st = '0;
  bit                            fresh = 1'b1;
  logic [drm_pkg::VERDICT_W-1:0] str_verdict = drm_pkg::V_RUNNING;
  bit [drm_pkg::CODE_W-1:0]      accum = '0;
  bit [drm_pkg::TAIL_W-1:0]      tail = '0;
  bit                            skipping = 1'b0;

  dfa_range_matcher_utf8 dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (cur_word.cmd),
    .state_index      (cur_word.st),
    .slot             (cur_word.slot),
    .range_low        (cur_word.lo),
    .range_high       (cur_word.hi),
    .target_state     (cur_word.tgt),
    .accept_flag      (cur_word.acc),
    .transition_count (cur_word.cnt),
    .data_byte        (cur_word.data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .matched          (matched),
    .cut_sequence     (cut_sequence),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  // first matching slot wins, no match rejects
  function automatic void take_char(input bit [drm_pkg::CODE_W-1:0] ch);
    bit [8:0] idx;
    if (str_verdict != drm_pkg::V_RUNNING) return;
    for (int unsigned k = 0; k < st_cnt[cur_st]; k++) begin
      idx = {cur_st, k[2:0]};
      if (ch >= tr_lo[idx] && ch <= tr_hi[idx]) begin
        cur_st = tr_tg[idx];
        if (st_acc[cur_st]) str_verdict = drm_pkg::V_ACCEPTED;
        return;
      end
    end
    str_verdict = drm_pkg::V_REJECTED;
  endfunction

  // first byte or end of a string loads the start state
  function automatic void open_string();
    if (fresh) begin
      fresh = 1'b0;
      cur_st = start_st;
      if (st_acc[cur_st]) str_verdict = drm_pkg::V_ACCEPTED;
    end
  endfunction

  // byte decoder: plain bytes or utf-8 with raw leads skipping their tail
  function automatic void decode_byte(input bit [7:0] b);
    int lead;
    lead = 0;
    if (enc_mode == ENC_BYTES) begin
      tail = '0;
      skipping = 1'b0;
      take_char({13'd0, b});
      return;
    end
    if (tail != 0) begin
      tail--;
      if (!skipping) begin
        accum = {accum[drm_pkg::CODE_W-7:0], b[5:0]};
        if (tail == 0) take_char(accum);
      end
      if (tail == 0) skipping = 1'b0;
      return;
    end
    while (lead < 8 && b[7-lead]) lead++;
    case (lead)
      0, 1: take_char({13'd0, b});
      2: begin
        accum = {16'd0, b[4:0]};
        tail = 3'd1;
      end
      3: begin
        accum = {17'd0, b[3:0]};
        tail = 3'd2;
      end
      4: begin
        accum = {18'd0, b[2:0]};
        tail = 3'd3;
      end
      default: begin
        take_char({13'd0, b});
        skipping = 1'b1;
        tail = 3'(lead - 1);
      end
    endcase
  endfunction

  // apply one accepted word, queue the verdict of an end word
  function automatic void step_matcher(input word_t w);
    bit [8:0] idx;
    idx = {w.st, w.slot};
    case (w.cmd)
      drm_pkg::CMD_TRANS: begin
        tr_lo[idx] = w.lo;
        tr_hi[idx] = w.hi;
        tr_tg[idx] = w.tgt;
      end
      drm_pkg::CMD_INFO: begin
        st_acc[w.st] = w.acc;
        st_cnt[w.st] = (w.cnt > MAX_TR) ? drm_pkg::COUNT_W'(MAX_TR) : w.cnt;
      end
      drm_pkg::CMD_DATA: begin
        open_string();
        decode_byte(w.data);
      end
      default: begin
        open_string();
        verdict_q.push_back('{matched: str_verdict == drm_pkg::V_ACCEPTED,
                              cut: tail != 0});
        fresh = 1'b1;
        str_verdict = drm_pkg::V_RUNNING;
        accum = '0;
        tail = '0;
        skipping = 1'b0;
      end
    endcase
  endfunction

  // ------------------------------------------------------ driver, monitor

  // word driver, fed from the pending queue
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = word_q.pop_front();
        cur_word <= next_word;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen     <= hold_reqs;
      hold_off_left <= HOLD_OFF;
    end
  end

  // result receiver with random stalls
  always @(negedge clk) begin
    if (hold_off_left != 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predict accepted words, check result words
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        words_taken++;
        step_matcher(cur_word);
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result word with no verdict pending");
          mismatches++;
        end else begin
          want_v = verdict_q.pop_front();
          if (matched !== want_v.matched) begin
            $error("matched: expected %0d, got %0b", want_v.matched, matched);
            mismatches++;
          end
          if (cut_sequence !== want_v.cut) begin
            $error("cut_sequence: expected %0d, got %0b", want_v.cut, cut_sequence);
            mismatches++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------- stimulus

  task automatic write_reg(input logic [drm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [drm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == drm_pkg::CFG_ENCODING) enc_mode = val[0];
    else start_st = val[drm_pkg::STATE_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // everything accepted, every verdict back, block settled
  task automatic wait_idle();
    while (word_q.size() != 0 || words_taken != words_sent || verdict_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // unused fields carry random values
  function automatic word_t rand_word(input logic [drm_pkg::CMD_W-1:0] cmd);
    word_t w;
    w.cmd  = cmd;
    w.st   = drm_pkg::STATE_W'($urandom);
    w.slot = drm_pkg::SLOT_W'($urandom);
    w.lo   = drm_pkg::CODE_W'($urandom);
    w.hi   = drm_pkg::CODE_W'($urandom);
    w.tgt  = drm_pkg::STATE_W'($urandom);
    w.acc  = 1'($urandom);
    w.cnt  = drm_pkg::COUNT_W'($urandom);
    w.data = drm_pkg::BYTE_W'($urandom);
    return w;
  endfunction

  task automatic push_word(input word_t w);
    word_q.push_back(w);
    words_sent++;
  endtask

  task automatic send_trans(input int s, input int k,
                            input logic [drm_pkg::CODE_W-1:0] lo,
                            input logic [drm_pkg::CODE_W-1:0] hi, input int tg);
    word_t w;
    w = rand_word(drm_pkg::CMD_TRANS);
    w.st   = drm_pkg::STATE_W'(s);
    w.slot = drm_pkg::SLOT_W'(k);
    w.lo   = lo;
    w.hi   = hi;
    w.tgt  = drm_pkg::STATE_W'(tg);
    slot_set[s][k] = 1'b1;
    push_word(w);
  endtask

  task automatic send_info(input int s, input bit acc, input int cnt);
    word_t w;
    w = rand_word(drm_pkg::CMD_INFO);
    w.st  = drm_pkg::STATE_W'(s);
    w.acc = acc;
    w.cnt = drm_pkg::COUNT_W'(cnt);
    push_word(w);
  endtask

  task automatic send_byte(input logic [7:0] b);
    word_t w;
    w = rand_word(drm_pkg::CMD_DATA);
    w.data = b;
    push_word(w);
  endtask

  task automatic send_end();
    push_word(rand_word(drm_pkg::CMD_END));
  endtask

  // written slots from 0 upwards, so a count never reaches an unwritten one
  function automatic int loaded_prefix(input int s);
    int p;
    p = 0;
    while (p < MAX_TR && slot_set[s][p]) p++;
    return p;
  endfunction

  // ascii bands, low code points, wide, single point, empty, catch-all
  task automatic pick_range(output logic [drm_pkg::CODE_W-1:0] lo,
                            output logic [drm_pkg::CODE_W-1:0] hi);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      lo = drm_pkg::CODE_W'($urandom_range(0, 127));
      hi = lo + drm_pkg::CODE_W'($urandom_range(0, 100));
    end else if (pick < 5) begin
      lo = drm_pkg::CODE_W'($urandom_range(0, 'h7FF));
      hi = lo + drm_pkg::CODE_W'($urandom_range(0, 'h3FFF));
    end else if (pick == 5) begin
      lo = drm_pkg::CODE_W'($urandom);
      hi = (lo > CODE_MAX - drm_pkg::CODE_W'('hFFFFF)) ? CODE_MAX :
           lo + drm_pkg::CODE_W'($urandom_range(0, 'hFFFFF));
    end else if (pick == 6) begin
      lo = drm_pkg::CODE_W'($urandom_range(0, 255));
      hi = lo;
    end else if (pick == 7) begin
      lo = drm_pkg::CODE_W'($urandom_range(1, CODE_MAX));
      hi = drm_pkg::CODE_W'($urandom_range(0, lo - 1));
    end else begin
      lo = '0;
      hi = CODE_MAX;
    end
  endtask

  // small automaton around the start state
  task automatic load_automaton(input logic [drm_pkg::STATE_W-1:0] start);
    logic [drm_pkg::CODE_W-1:0] lo, hi;
    int s, n, cnt, tg;
    active_st[0] = start;
    for (int i = 1; i < 8; i++) active_st[i] = drm_pkg::STATE_W'($urandom_range(0, NUM_ST - 1));
    for (int i = 0; i < 8; i++) begin
      s = active_st[i];
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, MAX_TR);
      for (int k = 0; k < n; k++) begin
        pick_range(lo, hi);
        if (k == n - 1 && $urandom_range(0, 1)) begin
          lo = '0;
          hi = CODE_MAX;
        end
        tg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_ST - 1)
                                         : active_st[$urandom_range(0, 7)];
        send_trans(s, k, lo, hi, tg);
      end
      cnt = (n == MAX_TR && $urandom_range(0, 1)) ? $urandom_range(MAX_TR, 15) : n;
      send_info(s, (i == 0) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 3) == 0),
                cnt);
    end
  endtask

  // stray load word anywhere in the automaton
  task automatic send_noise();
    logic [drm_pkg::CODE_W-1:0] lo, hi;
    int s, p;
    s = $urandom_range(0, NUM_ST - 1);
    if ($urandom_range(0, 1)) begin
      pick_range(lo, hi);
      send_trans(s, $urandom_range(0, MAX_TR - 1), lo, hi, $urandom_range(0, NUM_ST - 1));
    end else begin
      p = loaded_prefix(s);
      send_info(s, 1'($urandom),
                (p == MAX_TR) ? $urandom_range(0, 15) : $urandom_range(0, p));
    end
  endtask

  // one character: mostly well-formed, some broken or raw sequences
  task automatic send_char(input bit utf8);
    logic [drm_pkg::CODE_W-1:0] cp;
    int pick;
    cp = drm_pkg::CODE_W'($urandom);
    pick = $urandom_range(0, 19);
    if (!utf8) begin
      send_byte((pick < 12) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 255)));
    end else if (pick < 8) begin
      send_byte(8'($urandom_range(0, 127)));
    end else if (pick < 11) begin
      send_byte({3'b110, cp[10:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (pick < 13) begin
      send_byte({4'b1110, cp[15:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (pick < 15) begin
      send_byte({5'b11110, cp[20:18]});
      send_byte({2'b10, cp[17:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (pick == 15) begin
      send_byte({2'b10, cp[5:0]});
    end else if (pick == 16) begin
      send_byte(8'($urandom_range('hF8, 'hFF)));
      repeat ($urandom_range(0, 7)) send_byte(8'($urandom));
    end else if (pick == 17) begin
      send_byte({3'b110, cp[4:0]});
      send_byte(8'($urandom));
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  // one string, sometimes cut inside a multibyte sequence
  task automatic send_string(input bit utf8);
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
    repeat (n) send_char(utf8);
    if (utf8 && $urandom_range(0, 7) == 0) begin
      send_byte({4'b1110, 4'($urandom)});
      if ($urandom_range(0, 1)) send_byte({2'b10, 6'($urandom)});
    end
    send_end();
  endtask

  task automatic run_phase(input bit utf8, input logic [drm_pkg::STATE_W-1:0] start,
                           input int idle_pct, input int stall, input int quota,
                           input bit hold_off, input bit pause);
    int stop_at;
    wait_idle();
    write_reg(drm_pkg::CFG_ENCODING, {5'($urandom), utf8});
    write_reg(drm_pkg::CFG_START, start);
    @(posedge clk);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    stop_at = words_sent + quota;
    load_automaton(start);
    while (words_sent < stop_at) begin
      // sender pause half way: stop offering until every verdict is back
      if (pause && words_sent >= stop_at - quota / 2) begin
        pause = 1'b0;
        while (word_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 5) == 0) send_noise();
      send_string(utf8);
    end
    // leave a string open across the phase boundary now and then
    if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) send_char(utf8);
    if (hold_off) begin
      while (words_taken < words_sent - quota / 2) @(negedge clk);
      hold_reqs++;
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: byte mode, start 0
    write_reg(drm_pkg::CFG_ENCODING, drm_pkg::CFG_DATA_W'(ENC_BYTES));
    write_reg(drm_pkg::CFG_START, 6'd0);
    send_end();                                   // empty string, start not accepting
    send_trans(0, 0, 21'h41, 21'h5A, 1);
    send_trans(0, 1, 21'h30, 21'h20, 2);          // low above high never matches
    send_trans(0, 2, '0, CODE_MAX, 0);
    send_info(0, 1'b0, 3);
    send_info(1, 1'b1, 0);
    send_byte(8'h30);
    send_byte(8'h41);                             // enters accepting state 1
    send_byte(8'h42);                             // verdict already decided
    send_end();
    wait_idle();

    // directed: utf-8 decoding
    write_reg(drm_pkg::CFG_ENCODING, drm_pkg::CFG_DATA_W'(ENC_UTF8));
    send_byte(8'hC3);
    send_byte(8'h81);                             // two-byte code point
    send_byte(8'h9A);                             // lone continuation byte
    send_byte(8'hF8);                             // raw lead, four tail bytes skipped
    repeat (4) send_byte(8'h41);
    send_byte(8'h30);
    send_byte(8'hF0);
    send_byte(8'h9F);
    send_end();                                   // cut inside a sequence
    send_byte(8'hE2);                             // tail left open across the switch
    wait_idle();

    // directed: byte mode drops the open tail, then accepting and top start states
    write_reg(drm_pkg::CFG_ENCODING, drm_pkg::CFG_DATA_W'(ENC_BYTES));
    send_byte(8'h41);
    send_end();
    wait_idle();
    write_reg(drm_pkg::CFG_START, 6'd1);
    send_end();
    send_byte(8'h00);
    send_end();
    wait_idle();
    write_reg(drm_pkg::CFG_START, 6'd63);
    send_byte(8'h01);
    send_end();

    // random phases
    run_phase(ENC_UTF8,  drm_pkg::STATE_W'($urandom),  0,  0, 253, 1'b0, 1'b0);
    run_phase(ENC_UTF8,  6'd63,                       65,  0, 253, 1'b0, 1'b0);
    run_phase(ENC_BYTES, drm_pkg::STATE_W'($urandom),  0, 65, 253, 1'b1, 1'b0);
    run_phase(ENC_UTF8,  6'd0,                        37, 37, 253, 1'b0, 1'b1);
    run_phase(ENC_BYTES, 6'd63,                        0,  0, 253, 1'b0, 1'b0);
    run_phase(ENC_UTF8,  drm_pkg::STATE_W'($urandom), 37, 37, 253, 1'b1, 1'b0);
    wait_idle();

    if (mismatches == 0) begin
      $display("dfa_range_matcher_utf8: match");
    end else begin
      $display("dfa_range_matcher_utf8: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("dfa_range_matcher_utf8: mismatch");
    $finish;
  end

endmodule
